// ===== src/gcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Great circle distance package
// Shared types, fixed point constants and arithmetic helpers for the
// haversine distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

  // Angles in units of 2^-24 degree, wide enough for a longitude difference.
  localparam int ANGLE_W = 35;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  // CORDIC datapath word (Q30 values and angle accumulators).
  localparam int CW = 34;
  typedef logic signed [CW-1:0] cordic_t;

  // Clamped Q30 sine and cosine values, and nonnegative Q30 magnitudes.
  typedef logic signed [31:0] qval_t;
  typedef logic [30:0] qmag_t;

  localparam angle_t DEG90  = 35'sd1509949440;
  localparam angle_t DEG180 = 35'sd3019898880;
  localparam angle_t DEG360 = 35'sd6039797760;

  localparam cordic_t CORDIC_K = 34'sd652032874;
  localparam cordic_t Q_ONE    = 34'sd1073741824;

  // Arctangent of 2^-i in units of 2^-24 degree.
  localparam logic [29:0] ARC_TABLE [32] = '{
    30'd754974720, 30'd445687602, 30'd235489089, 30'd119537938, 30'd60000934,
    30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
    30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671, 30'd29335,
    30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229,
    30'd115, 30'd57, 30'd29, 30'd14, 30'd7, 30'd4, 30'd2, 30'd1, 30'd0
  };

  // Radians per degree scaled by 2^32; times an angle in 2^-24 degree the product is in radians * 2^56.
  localparam logic [26:0] RAD_PER_DEG  = 27'd74961321;
  localparam logic [23:0] DIST_MAX     = 24'hFFFFFF;
  localparam logic [23:0] RADIUS_RESET = 24'd1013453;

  // Arctangent table entry as a datapath word.
  function automatic cordic_t arc(int unsigned i);
    return $signed({4'b0000, ARC_TABLE[i]});
  endfunction

  // Arithmetic right shift that truncates toward zero.
  function automatic cordic_t shr0(cordic_t v, int unsigned s);
    cordic_t mag;
    mag = v[CW-1] ? -v : v;
    mag = mag >> s;
    return v[CW-1] ? -mag : mag;
  endfunction

  // Clamp a datapath word to [-1, 1] in Q30.
  function automatic qval_t clamp_q(cordic_t v);
    cordic_t r;
    if (v > Q_ONE) begin
      r = Q_ONE;
    end else if (v < -Q_ONE) begin
      r = -Q_ONE;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

  // Q30 product, truncated toward zero.
  function automatic qval_t qmul(qval_t a, qval_t b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    qval_t       r;
    ma = a[31] ? 32'(-a) : 32'(a);
    mb = b[31] ? 32'(-b) : 32'(b);
    p  = 64'(ma) * 64'(mb);
    r  = $signed(p[61:30]);
    return (a[31] != b[31]) ? -r : r;
  endfunction

endpackage

// ===== src/great_circle_distance_unit.sv =====
// Throughput: one item per cycle; every stage holds one item, and the whole
// pipeline holds its contents while a finished result is not taken.
// The latency is set by the two CORDIC chains and the 32-stage square root.
// Reset clears all valid bits and loads the default earth radius.
// ----------------------------------------------------------------------------
// Great circle distance unit
// Haversine distance between two latitude/longitude points, fully pipelined.
// ----------------------------------------------------------------------------
module great_circle_distance_unit import gcd_pkg::*; #(
  parameter int ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               config_write,
  input  logic [23:0]        config_data,
  input  logic               input_valid,
  output logic               input_ready,
  input  logic signed [27:0] first_latitude,
  input  logic signed [28:0] first_longitude,
  input  logic signed [27:0] second_latitude,
  input  logic signed [28:0] second_longitude,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [23:0]        distance
);

  localparam int STEPS = (ITERATIONS > 32) ? 32 : ITERATIONS;

  logic        en;
  logic [23:0] radius;

  logic        v_in;
  angle_t      half_dlat;
  angle_t      half_dlon;
  angle_t      lat_first;
  angle_t      lat_second;

  logic        v_trig;
  qval_t       sin_lat;
  qval_t       sin_lon;
  qval_t       cos_first;
  qval_t       cos_second;

  logic        v_hav;
  qmag_t       a_val;
  qmag_t       b_val;
  logic        v_root;
  qmag_t       root_a;
  qmag_t       root_b;
  logic        v_atan;
  qmag_t       central;

  // The pipeline advances unless a finished result is waiting.
  assign en          = !result_valid || result_ready;
  assign input_ready = en;

  // Earth radius register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (config_write) begin
      radius <= config_data;
    end
  end

  // Input stage: half differences and full latitudes in 2^-24 degree.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else if (en) begin
      v_in <= input_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      half_dlat  <= (angle_t'(second_latitude) - angle_t'(first_latitude)) <<< 3;
      half_dlon  <= (angle_t'(second_longitude) - angle_t'(first_longitude)) <<< 3;
      lat_first  <= angle_t'(first_latitude) <<< 4;
      lat_second <= angle_t'(second_latitude) <<< 4;
    end
  end

  gcd_sincos #(.STEPS(STEPS)) u_sc_dlat (
    .clk, .rst, .en, .in_valid(v_in), .angle(half_dlat),
    .out_valid(v_trig), .sin_val(sin_lat), .cos_val()
  );

  gcd_sincos #(.STEPS(STEPS)) u_sc_dlon (
    .clk, .rst, .en, .in_valid(v_in), .angle(half_dlon),
    .out_valid(), .sin_val(sin_lon), .cos_val()
  );

  gcd_sincos #(.STEPS(STEPS)) u_sc_lat1 (
    .clk, .rst, .en, .in_valid(v_in), .angle(lat_first),
    .out_valid(), .sin_val(), .cos_val(cos_first)
  );

  gcd_sincos #(.STEPS(STEPS)) u_sc_lat2 (
    .clk, .rst, .en, .in_valid(v_in), .angle(lat_second),
    .out_valid(), .sin_val(), .cos_val(cos_second)
  );

  gcd_hav u_hav (
    .clk, .rst, .en, .in_valid(v_trig),
    .sin_lat, .sin_lon, .cos_first, .cos_second,
    .out_valid(v_hav), .a_val, .b_val
  );

  gcd_sqrt u_sqrt_a (
    .clk, .rst, .en, .in_valid(v_hav), .radicand(a_val),
    .out_valid(v_root), .root(root_a)
  );

  gcd_sqrt u_sqrt_b (
    .clk, .rst, .en, .in_valid(v_hav), .radicand(b_val),
    .out_valid(), .root(root_b)
  );

  gcd_atan #(.STEPS(STEPS)) u_atan (
    .clk, .rst, .en, .in_valid(v_root), .y_in(root_a), .x_in(root_b),
    .out_valid(v_atan), .angle(central)
  );

  gcd_scale u_scale (
    .clk, .rst, .en, .in_valid(v_atan), .angle(central), .radius,
    .out_valid(result_valid), .distance
  );

endmodule

// ===== src/gcd_sincos.sv =====
// ----------------------------------------------------------------------------
// Sine and cosine pipeline
// Reduces an angle to [-90, 90] degrees and runs one CORDIC rotation step
// per register stage.
// ----------------------------------------------------------------------------
module gcd_sincos import gcd_pkg::*; #(
  parameter int STEPS = 24
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  angle_t angle,
  output logic   out_valid,
  output qval_t  sin_val,
  output qval_t  cos_val
);

  angle_t  wrapped;
  angle_t  folded;
  logic    flip;

  cordic_t xs [STEPS+1];
  cordic_t ys [STEPS+1];
  cordic_t zs [STEPS+1];
  logic    fl [STEPS+1];
  logic    vl [STEPS+1];

  cordic_t xf;
  cordic_t yf;

  // Wrap into [-180, 180) and fold into [-90, 90] with a sign flip.
  always_comb begin
    if (angle >= DEG180) begin
      wrapped = angle - DEG360;
    end else if (angle < -DEG180) begin
      wrapped = angle + DEG360;
    end else begin
      wrapped = angle;
    end
    flip = 1'b1;
    if (wrapped > DEG90) begin
      folded = wrapped - DEG180;
    end else if (wrapped < -DEG90) begin
      folded = wrapped + DEG180;
    end else begin
      folded = wrapped;
      flip   = 1'b0;
    end
  end

  // Reduction stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else if (en) begin
      vl[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zs[0] <= cordic_t'(folded);
      fl[0] <= flip;
    end
  end

  assign xs[0] = CORDIC_K;
  assign ys[0] = '0;

  // One rotation step per stage.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else if (en) begin
        vl[i+1] <= vl[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fl[i+1] <= fl[i];
        if (!zs[i][CW-1]) begin
          xs[i+1] <= xs[i] - shr0(ys[i], i);
          ys[i+1] <= ys[i] + shr0(xs[i], i);
          zs[i+1] <= zs[i] - arc(i);
        end else begin
          xs[i+1] <= xs[i] + shr0(ys[i], i);
          ys[i+1] <= ys[i] - shr0(xs[i], i);
          zs[i+1] <= zs[i] + arc(i);
        end
      end
    end
  end

  // Undo the fold and clamp to the Q30 unit range.
  assign xf = fl[STEPS] ? -xs[STEPS] : xs[STEPS];
  assign yf = fl[STEPS] ? -ys[STEPS] : ys[STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vl[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_val <= clamp_q(yf);
      cos_val <= clamp_q(xf);
    end
  end

endmodule

// ===== src/gcd_hav.sv =====
// ----------------------------------------------------------------------------
// Haversine term
// Forms a = sin^2(dlat/2) + cos(lat1)cos(lat2)sin^2(dlon/2) over three
// stages and also gives 1 - a.
// ----------------------------------------------------------------------------
module gcd_hav import gcd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  qval_t sin_lat,
  input  qval_t sin_lon,
  input  qval_t cos_first,
  input  qval_t cos_second,
  output logic  out_valid,
  output qmag_t a_val,
  output qmag_t b_val
);

  logic  v1;
  logic  v2;
  qval_t sq_lat;
  qval_t cc;
  qval_t sq_lon;
  qval_t sq_lat2;
  qval_t prod;

  logic signed [32:0] sum;
  qmag_t              a_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Sum and clamp to [0, 1].
  always_comb begin
    sum = 33'(sq_lat2) + 33'(prod);
    if (sum < 0) begin
      a_clamped = '0;
    end else if (sum > 33'sd1073741824) begin
      a_clamped = 31'd1073741824;
    end else begin
      a_clamped = sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_lat  <= qmul(sin_lat, sin_lat);
      cc      <= qmul(cos_first, cos_second);
      sq_lon  <= qmul(sin_lon, sin_lon);
      sq_lat2 <= sq_lat;
      prod    <= qmul(cc, sq_lon);
      a_val   <= a_clamped;
      b_val   <= 31'd1073741824 - a_clamped;
    end
  end

endmodule

// ===== src/gcd_sqrt.sv =====
// ----------------------------------------------------------------------------
// Square root pipeline
// Exact bit-by-bit integer root of a Q30 value, one result bit per stage.
// ----------------------------------------------------------------------------
module gcd_sqrt import gcd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  qmag_t radicand,
  output logic  out_valid,
  output qmag_t root
);

  localparam int STAGES = 32;

  logic [63:0] rem  [STAGES+1];
  logic [63:0] res  [STAGES+1];
  logic        vl   [STAGES+1];

  assign rem[0] = 64'(radicand) << 30;
  assign res[0] = '0;
  assign vl[0]  = in_valid;

  for (genvar k = 0; k < STAGES; k++) begin : g_bit
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;

    assign trial = res[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k+1] <= 1'b0;
      end else if (en) begin
        vl[k+1] <= vl[k];
      end
    end

    // Keep the bit when the trial fits under the remainder.
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          res[k+1] <= (res[k] >> 1) + BIT;
        end else begin
          rem[k+1] <= rem[k];
          res[k+1] <= res[k] >> 1;
        end
      end
    end
  end

  assign out_valid = vl[STAGES];
  assign root      = res[STAGES][30:0];

endmodule

// ===== src/gcd_atan.sv =====
// ----------------------------------------------------------------------------
// Arctangent pipeline
// CORDIC vectoring of (x, y) with one step per stage; the angle is in units
// of 2^-24 degree and clamped at zero.
// ----------------------------------------------------------------------------
module gcd_atan import gcd_pkg::*; #(
  parameter int STEPS = 24
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  qmag_t y_in,
  input  qmag_t x_in,
  output logic  out_valid,
  output qmag_t angle
);

  cordic_t xs [STEPS+1];
  cordic_t ys [STEPS+1];
  cordic_t zs [STEPS+1];
  logic    vl [STEPS+1];

  assign xs[0] = $signed(CW'(x_in));
  assign ys[0] = $signed(CW'(y_in));
  assign zs[0] = '0;
  assign vl[0] = in_valid;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else if (en) begin
        vl[i+1] <= vl[i];
      end
    end

    // Rotate toward the x axis and accumulate the angle.
    always_ff @(posedge clk) begin
      if (en) begin
        if (!ys[i][CW-1]) begin
          xs[i+1] <= xs[i] + shr0(ys[i], i);
          ys[i+1] <= ys[i] - shr0(xs[i], i);
          zs[i+1] <= zs[i] + arc(i);
        end else begin
          xs[i+1] <= xs[i] - shr0(ys[i], i);
          ys[i+1] <= ys[i] + shr0(xs[i], i);
          zs[i+1] <= zs[i] - arc(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vl[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zs[STEPS][CW-1] ? '0 : zs[STEPS][30:0];
    end
  end

endmodule

// ===== src/gcd_scale.sv =====
// ----------------------------------------------------------------------------
// Distance scaling
// Converts the half central angle to radians, multiplies by the radius and
// by two, rounds and saturates to the output width.
// ----------------------------------------------------------------------------
module gcd_scale import gcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  qmag_t       angle,
  input  logic [23:0] radius,
  output logic        out_valid,
  output logic [23:0] distance
);

  logic        v1;
  logic        v2;
  logic [57:0] rad_prod;
  logic [32:0] rad;
  logic [56:0] dist_prod;
  logic [57:0] rounded;
  logic [26:0] quot;

  assign rad_prod = 58'(angle) * 58'(RAD_PER_DEG);
  assign rounded  = 58'(dist_prod) + (58'd1 << 30);
  assign quot     = rounded[57:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Radians, then radius product, then round and saturate.
  always_ff @(posedge clk) begin
    if (en) begin
      rad       <= rad_prod[56:24];
      dist_prod <= 57'(rad) * 57'(radius);
      distance  <= (quot > 27'(DIST_MAX)) ? DIST_MAX : quot[23:0];
    end
  end

endmodule

// ===== src/gcd_checker.sv =====
// ----------------------------------------------------------------------------
// Great circle distance checker
// Port-level assertions on the distance unit, bound to the top level.
// ----------------------------------------------------------------------------
module gcd_checker (
  input logic               clk,
  input logic               rst,
  input logic               config_write,
  input logic [23:0]        config_data,
  input logic               input_valid,
  input logic               input_ready,
  input logic signed [27:0] first_latitude,
  input logic signed [28:0] first_longitude,
  input logic signed [27:0] second_latitude,
  input logic signed [28:0] second_longitude,
  input logic               result_valid,
  input logic               result_ready,
  input logic [23:0]        distance
);

  // A waiting result stays and holds its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(distance))
    else $error("result changed while stalled");

  // The input side only stalls while a result waits untaken.
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    input_ready == (!result_valid || result_ready))
    else $error("input ready does not follow output stall");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // A stalled result does not let new input in.
  a_no_accept_stall: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !input_ready)
    else $error("input accepted during output stall");

endmodule

bind great_circle_distance_unit gcd_checker u_gcd_checker (.*);

// ===== sim/great_circle_distance_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Great circle distance unit testbench
// Drives coordinate pairs through the haversine pipeline with random idling
// on both handshakes, predicts each distance with a bit-exact fixed point
// model and compares every result against the oldest pending prediction.
// ----------------------------------------------------------------------------
module great_circle_distance_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gcd_pkg::*;

  localparam int ITER = 24;
  localparam int LATENCY = 2 * ITER + 42;
  localparam int LAT_MAX = 94371840;
  localparam int LON_MAX = 188743680;
  localparam longint CYCLE_LIMIT = 400000;

  // Predicts distances and keeps them in order of input transfer.
  class distance_scoreboard;
    logic [23:0] pending_distances[$];
    logic [23:0] radius;
    int error_count;
    int checked_count;

    function new();
      radius = RADIUS_RESET;
      error_count = 0;
      checked_count = 0;
    endfunction

    static function longint trunc_shift(longint v, int s);
      longint m;
      m = v < 0 ? -v : v;
      m = m >>> s;
      return v < 0 ? -m : m;
    endfunction

    static function longint q_product(longint a, longint b);
      longint ua;
      longint ub;
      longint r;
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      r = (ua * ub) >>> 30;
      return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    static function longint limit(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // CORDIC rotation for sine and cosine of an angle in 2^-24 degree.
    static function void rotate(longint ang, output longint s, output longint c);
      longint z;
      longint x;
      longint y;
      longint xn;
      bit flip;
      z = ang % longint'(DEG360);
      x = CORDIC_K;
      y = 0;
      flip = 0;
      if (z < 0) z += DEG360;
      if (z >= DEG180) z -= DEG360;
      if (z > DEG90) begin
        z -= DEG180;
        flip = 1;
      end else if (z < -longint'(DEG90)) begin
        z += DEG180;
        flip = 1;
      end
      for (int i = 0; i < ITER; i++) begin
        if (z >= 0) begin
          xn = x - trunc_shift(y, i);
          y = y + trunc_shift(x, i);
          z -= ARC_TABLE[i];
        end else begin
          xn = x + trunc_shift(y, i);
          y = y - trunc_shift(x, i);
          z += ARC_TABLE[i];
        end
        x = xn;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      s = limit(y, -longint'(Q_ONE), Q_ONE);
      c = limit(x, -longint'(Q_ONE), Q_ONE);
    endfunction

    // Exact bit-serial square root of a Q30 value.
    static function longint root_q30(longint a);
      longint unsigned v;
      longint unsigned res;
      longint unsigned b;
      v = longint'(a) << 30;
      res = 0;
      b = 64'd1 << 62;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // CORDIC vectoring for the central angle.
    static function longint vector_angle(longint y, longint x);
      longint z;
      longint xn;
      z = 0;
      for (int i = 0; i < ITER; i++) begin
        if (y >= 0) begin
          xn = x + trunc_shift(y, i);
          y = y - trunc_shift(x, i);
          z += ARC_TABLE[i];
        end else begin
          xn = x - trunc_shift(y, i);
          y = y + trunc_shift(x, i);
          z -= ARC_TABLE[i];
        end
        x = xn;
      end
      return z < 0 ? 0 : z;
    endfunction

    function void note_input(longint lat1, longint lon1, longint lat2, longint lon2);
      longint s_lat;
      longint s_lon;
      longint c1;
      longint c2;
      longint unused;
      longint hav;
      longint z;
      longint unsigned t;
      longint unsigned d;
      rotate((lat2 - lat1) * 8, s_lat, unused);
      rotate((lon2 - lon1) * 8, s_lon, unused);
      rotate(lat1 * 16, unused, c1);
      rotate(lat2 * 16, unused, c2);
      hav = q_product(s_lat, s_lat) +
            q_product(q_product(c1, c2), q_product(s_lon, s_lon));
      hav = limit(hav, 0, Q_ONE);
      z = vector_angle(root_q30(hav), root_q30(Q_ONE - hav));
      t = (longint'(z) * RAD_PER_DEG) >> 24;
      d = (t * radius + (64'd1 << 30)) >> 31;
      if (d > DIST_MAX) d = DIST_MAX;
      pending_distances.push_back(d[23:0]);
    endfunction

    function void check_result(logic [23:0] actual);
      logic [23:0] expected;
      if (pending_distances.size() == 0) begin
        $display("%0t: unexpected distance, expected none, actual %0d", $time, actual);
        error_count++;
        return;
      end
      expected = pending_distances.pop_front();
      checked_count++;
      if (actual !== expected) begin
        $display("%0t: distance mismatch, expected %0d, actual %0d",
                 $time, expected, actual);
        error_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic config_write;
  logic [23:0] config_data;
  logic input_valid;
  logic input_ready;
  logic signed [27:0] first_latitude;
  logic signed [28:0] first_longitude;
  logic signed [27:0] second_latitude;
  logic signed [28:0] second_longitude;
  logic result_valid;
  logic result_ready;
  logic [23:0] distance;

  distance_scoreboard board;
  int sender_idle_pct;
  int receiver_idle_pct;
  longint cycle_count;

  great_circle_distance_unit #(.ITERATIONS(ITER)) dut (
    .clk(clk),
    .rst(rst),
    .config_write(config_write),
    .config_data(config_data),
    .input_valid(input_valid),
    .input_ready(input_ready),
    .first_latitude(first_latitude),
    .first_longitude(first_longitude),
    .second_latitude(second_latitude),
    .second_longitude(second_longitude),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .distance(distance)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver side: random stalls and result checking.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && result_valid && result_ready) begin
      board.check_result(distance);
    end
    if (rst) begin
      result_ready <= 0;
    end else begin
      result_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offers one coordinate pair and holds it until the transfer. Valid stays
  // high afterwards; the next pair, an idle cycle or a drain replaces it.
  task automatic send_pair(longint lat1, longint lon1, longint lat2, longint lon2);
    logic signed [27:0] la1;
    logic signed [28:0] lo1;
    logic signed [27:0] la2;
    logic signed [28:0] lo2;
    la1 = 28'(lat1);
    lo1 = 29'(lon1);
    la2 = 28'(lat2);
    lo2 = 29'(lon2);
    while ($urandom_range(99) < sender_idle_pct) begin
      input_valid <= 0;
      @(posedge clk);
    end
    input_valid <= 1;
    first_latitude <= la1;
    first_longitude <= lo1;
    second_latitude <= la2;
    second_longitude <= lo2;
    @(posedge clk);
    while (!input_ready) @(posedge clk);
    board.note_input(la1, lo1, la2, lo2);
  endtask

  // Stops sending and waits for the pipeline to drain.
  task automatic drain();
    input_valid <= 0;
    while (board.pending_distances.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_radius(logic [23:0] value);
    drain();
    config_write <= 1;
    config_data <= value;
    board.radius = value;
    @(posedge clk);
    config_write <= 0;
  endtask

  function automatic logic signed [27:0] rand_lat();
    return $signed(28'($urandom_range(2 * LAT_MAX)) - 28'(LAT_MAX));
  endfunction

  function automatic logic signed [28:0] rand_lon();
    return $signed(29'($urandom_range(2 * LON_MAX)) - 29'(LON_MAX));
  endfunction

  // Mostly in-range coordinates; sometimes raw bit patterns or nearby points.
  task automatic send_random();
    logic signed [27:0] lat1;
    logic signed [28:0] lon1;
    int kind;
    kind = $urandom_range(9);
    lat1 = rand_lat();
    lon1 = rand_lon();
    if (kind == 0) begin
      send_pair($urandom, $urandom, $urandom, $urandom);
    end else if (kind < 3) begin
      send_pair(lat1, lon1, lat1 + $signed(28'($urandom_range(2000)) - 28'd1000),
                lon1 + $signed(29'($urandom_range(2000)) - 29'd1000));
    end else begin
      send_pair(lat1, lon1, rand_lat(), rand_lon());
    end
  endtask

  initial begin
    logic [23:0] radii[4];
    board = new();
    cycle_count = 0;
    rst = 1;
    config_write = 0;
    config_data = 0;
    input_valid = 0;
    first_latitude = 0;
    first_longitude = 0;
    second_latitude = 0;
    second_longitude = 0;
    result_ready = 0;
    sender_idle_pct = 20;
    receiver_idle_pct = 57;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: same point, poles, antipodes, date line, extreme bit patterns.
    send_pair(0, 0, 0, 0);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);
    send_pair(0, 0, 0, LON_MAX);
    send_pair(0, -LON_MAX, 0, LON_MAX);
    send_pair(0, LON_MAX - 1, 0, -LON_MAX + 1);
    send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_pair(-LAT_MAX, 12345, LAT_MAX, -54321);
    send_pair(28'sh7FFFFFF, 29'sh0FFFFFFF, 28'sh8000000, 29'sh10000000);
    send_pair(28'sh8000000, 29'sh10000000, 28'sh7FFFFFF, 29'sh0FFFFFFF);
    send_pair(-1, -1, 0, 0);
    send_pair(0, 0, 1, 1);
    send_pair(LAT_MAX / 2, LON_MAX / 2, -LAT_MAX / 2, -LON_MAX / 2);
    send_pair(28'shAAAAAAA, 29'sh15555555, 28'sh5555555, 29'sh0AAAAAAA);

    // Radius extremes: zero, one, maximum (saturates), back to default.
    radii = '{24'd0, 24'd1, 24'hFFFFFF, RADIUS_RESET};
    foreach (radii[r]) begin
      set_radius(radii[r]);
      send_pair(LAT_MAX, 0, -LAT_MAX, 0);
      send_pair(0, 0, 0, LON_MAX);
      send_pair(0, 0, 1000, 1000);
    end

    // Random phases with different idling patterns and radii.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 57 : 0;
      receiver_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 20 : 0;
      set_radius(phase == 1 ? 24'($urandom_range(1, 24'hFFFFFF)) : RADIUS_RESET);
      for (int n = 0; n < 230; n++) begin
        send_random();
        if (n == 100) drain();
      end
    end

    drain();
    $display("Covered %0d distances over directed extremes and three idling phases,",
             board.checked_count);
    $display("with radius settings zero, one, maximum, default and random.");
    if (board.error_count == 0 && board.pending_distances.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
src/gcd_pkg.sv
src/gcd_sincos.sv
src/gcd_hav.sv
src/gcd_sqrt.sv
src/gcd_atan.sv
src/gcd_scale.sv
src/great_circle_distance_unit.sv
src/gcd_checker.sv
sim/great_circle_distance_unit_tb.sv
